FILE: hdl/ranked_top_k_table_insert_core_assert.svh
// assertion macros shared by the checker of the ranked top-k table
// needs clk and rst_n in the scope where a macro is used
`ifndef RANKED_TOP_K_TABLE_INSERT_CORE_ASSERT_SVH
`define RANKED_TOP_K_TABLE_INSERT_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RTKI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ranked top-k table assertion failed");

// next-cycle implication, disabled while in reset
`define RTKI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ranked top-k table assertion failed");

`endif

FILE: hdl/rtki_pkg.sv
// shared types and constants of the ranked top-k table
// no dependencies
`default_nettype none

package rtki_pkg;

    localparam int SCORE_W      = 31;
    localparam int LEVEL_W      = 16;
    localparam int EPISODE_W    = 3;
    localparam int RANK_W       = 3;
    localparam int NUM_ENTRIES_DEF = 8;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic [SCORE_W-1:0]   score;
        logic [LEVEL_W-1:0]   level;
        logic [EPISODE_W-1:0] episode;
    } entry_t;

    // control handed along the chain of cells
    typedef struct packed {
        logic insert_en;
        logic prev_beats;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/rtki_req_if.sv
// request channel of the ranked top-k table
// depends on rtki_pkg
`default_nettype none

interface rtki_req_if
    import rtki_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [SCORE_W-1:0]   new_score;
    logic [LEVEL_W-1:0]   new_level;
    logic [EPISODE_W-1:0] new_episode;
    logic [RANK_W-1:0]    read_rank;

    modport source (
        output valid, cmd, new_score, new_level, new_episode, read_rank,
        input  ready
    );

    modport sink (
        input  valid, cmd, new_score, new_level, new_episode, read_rank,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/rtki_rsp_if.sv
// response channel of the ranked top-k table
// depends on rtki_pkg
`default_nettype none

interface rtki_rsp_if
    import rtki_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 placed;
    logic [RANK_W-1:0]    placed_rank;
    logic [SCORE_W-1:0]   entry_score;
    logic [LEVEL_W-1:0]   entry_level;
    logic [EPISODE_W-1:0] entry_episode;

    modport source (
        output valid, placed, placed_rank, entry_score, entry_level, entry_episode,
        input  ready
    );

    modport sink (
        input  valid, placed, placed_rank, entry_score, entry_level, entry_episode,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/rtki_cell.sv
// one rank of the table: holds an entry, compares it with the new one
// depends on rtki_pkg
`default_nettype none

module rtki_cell
    import rtki_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     new_entry,
    input  wire entry_t     prev_entry,
    output entry_t          entry,
    output logic            beats
);

    entry_t entry_reg;
    entry_t entry_next;

    // new entry ranks above the stored one; exact ties go below
    assign beats = (new_entry.score > entry_reg.score) ||
                   ((new_entry.score == entry_reg.score) &&
                    (new_entry.level > entry_reg.level));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert_en)
        begin
            if (ctrl.prev_beats)
            begin
                entry_next = prev_entry;
            end
            else if (beats)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: hdl/ranked_top_k_table_insert_core.sv
// ranked top-k table: top level with the chain of cells and the response register
// depends on rtki_pkg, rtki_req_if, rtki_rsp_if and rtki_cell
//
// usage
//   req carries one request: cmd insert (new_score, new_level, new_episode) or
//   cmd read (read_rank). rsp returns exactly one response per request.
//   an insert goes in front of the first stored entry with a lower score, or
//   an equal score and a lower level; entries below move down a rank and the
//   last one drops out. placed/placed_rank say where it landed.
//   a read returns the entry at read_rank, zeros beyond the table.
// latency and throughput
//   one request per cycle while the receiver takes responses; the response is
//   valid the cycle after acceptance. every cell compares against the new entry
//   at once, so table depth adds no register beyond the response register.
// reset
//   rst_n clears every entry to zero and drops rsp.valid.
// back-pressure
//   req.ready is high while the response register is empty or being taken,
//   so a stalled receiver holds the response and stalls new requests.
`default_nettype none

module ranked_top_k_table_insert_core
    import rtki_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rtki_req_if.sink   req,
    rtki_rsp_if.source rsp
);

    // only ranks reachable by a 3-bit read_rank need a read path
    localparam int READ_SLOTS = (NUM_ENTRIES < (1 << RANK_W)) ? NUM_ENTRIES : (1 << RANK_W);

    entry_t                 new_entry;
    entry_t                 entries [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] beats;
    logic                   req_accept;
    logic                   insert_en;

    // response register
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic                 placed_reg;
    logic                 placed_next;
    logic [RANK_W-1:0]    placed_rank_reg;
    logic [RANK_W-1:0]    placed_rank_next;
    entry_t               read_entry_reg;
    entry_t               read_entry_next;

    entry_t               read_sel;
    logic [RANK_W-1:0]    first_rank;

    assign req.ready  = !rsp_valid_reg || rsp.ready;
    assign req_accept = req.valid && req.ready;
    assign insert_en  = req_accept && (req.cmd == CMD_INSERT);

    assign new_entry.score   = req.new_score;
    assign new_entry.level   = req.new_level;
    assign new_entry.episode = req.new_episode;

    // chain of cells, rank 0 first; each takes its upper neighbour's entry on a shift
    genvar g;
    generate
        for (g = 0; g < NUM_ENTRIES; g++)
        begin : g_cell
            cell_ctrl_t ctrl;
            entry_t     prev_entry;

            if (g == 0)
            begin : g_head
                assign ctrl.prev_beats = 1'b0;
                assign prev_entry      = '0;
            end
            else
            begin : g_body
                assign ctrl.prev_beats = beats[g-1];
                assign prev_entry      = entries[g-1];
            end
            assign ctrl.insert_en = insert_en;

            rtki_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_entry  (new_entry),
                .prev_entry (prev_entry),
                .entry      (entries[g]),
                .beats      (beats[g])
            );
        end
    endgenerate

    // table stays sorted, so beats is a run of ones from the landing rank down;
    // its first one is the landing rank (low bits only on wide tables)
    always_comb
    begin
        first_rank = '0;
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            if (beats[k] && ((k == 0) || !beats[(k == 0) ? 0 : k-1]))
            begin
                first_rank = first_rank | RANK_W'(k);
            end
        end
    end

    // read mux over the ranks a request can name
    always_comb
    begin
        read_sel = '0;
        for (int k = 0; k < READ_SLOTS; k++)
        begin
            if (req.read_rank == RANK_W'(k))
            begin
                read_sel = entries[k];
            end
        end
    end

    always_comb
    begin
        rsp_valid_next   = rsp_valid_reg;
        placed_next      = placed_reg;
        placed_rank_next = placed_rank_reg;
        read_entry_next  = read_entry_reg;
        if (req_accept)
        begin
            rsp_valid_next = 1'b1;
            if (req.cmd == CMD_READ)
            begin
                placed_next      = 1'b0;
                placed_rank_next = '0;
                read_entry_next  = read_sel;
            end
            else
            begin
                placed_next      = |beats;
                placed_rank_next = first_rank;
                read_entry_next  = '0;
            end
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        placed_reg      <= placed_next;
        placed_rank_reg <= placed_rank_next;
        read_entry_reg  <= read_entry_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.placed        = placed_reg;
    assign rsp.placed_rank   = placed_rank_reg;
    assign rsp.entry_score   = read_entry_reg.score;
    assign rsp.entry_level   = read_entry_reg.level;
    assign rsp.entry_episode = read_entry_reg.episode;

endmodule

`default_nettype wire

FILE: hdl/rtki_checker.sv
// port-level checks of the ranked top-k table, bound to the top level
// depends on rtki_pkg and the assertion macro header
`default_nettype none

`include "ranked_top_k_table_insert_core_assert.svh"

module rtki_checker
    import rtki_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_ready,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire logic                 placed,
    input wire logic [RANK_W-1:0]    placed_rank,
    input wire logic [SCORE_W-1:0]   entry_score,
    input wire logic [LEVEL_W-1:0]   entry_level,
    input wire logic [EPISODE_W-1:0] entry_episode
);

    // a stalled response holds still
    `RTKI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(placed) && $stable(placed_rank) && $stable(entry_score) && $stable(entry_level) && $stable(entry_episode))

    // every accepted request shows its response the next cycle
    `RTKI_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready, rsp_valid)

    // a request is taken only when the response slot frees up
    `RTKI_ASSERT_SAME(a_ready_slot, req_ready, !rsp_valid || rsp_ready)

    // a placed insert reports no entry fields
    `RTKI_ASSERT_SAME(a_insert_clean, rsp_valid && placed, entry_score == '0 && entry_level == '0 && entry_episode == '0)

endmodule

bind ranked_top_k_table_insert_core rtki_checker u_rtki_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .placed        (rsp.placed),
    .placed_rank   (rsp.placed_rank),
    .entry_score   (rsp.entry_score),
    .entry_level   (rsp.entry_level),
    .entry_episode (rsp.entry_episode)
);

`default_nettype wire

FILE: tb/tb_top.sv
// testbench of the ranked top-k table insertion core: random and directed requests,
// a scoreboard that keeps its own copy of the ranked table and checks every response
// depends on rtki_pkg, rtki_req_if, rtki_rsp_if and ranked_top_k_table_insert_core

module tb_top;
    import rtki_pkg::*;

    localparam int TABLE_DEPTH     = NUM_ENTRIES_DEF;
    localparam int RANDOM_REQUESTS = 1830;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int LONG_HOLD       = 300;
    localparam int MAX_REPORTS     = 10;

    typedef logic [RANK_W-1:0] rank_t;

    // one request as seen on the request channel
    typedef struct {
        logic                 cmd;
        logic [SCORE_W-1:0]   score;
        logic [LEVEL_W-1:0]   level;
        logic [EPISODE_W-1:0] episode;
        rank_t                rank;
    } request_t;

    // one response: placement report plus the entry read back
    typedef struct {
        logic   placed;
        rank_t  placed_rank;
        entry_t entry;
    } outcome_t;

    // keeps its own ranked table and the queue of outcomes still owed by the block
    class ranked_table_scoreboard;
        entry_t      board[TABLE_DEPTH];
        outcome_t    expected_outcomes[$];
        int unsigned mismatches;

        function new();
            foreach (board[k])
                board[k] = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        // apply one accepted request to the table and queue the outcome it owes
        function void note_request(request_t r);
            outcome_t o;
            o.placed      = 1'b0;
            o.placed_rank = '0;
            o.entry       = '0;
            if (r.cmd == CMD_READ)
            begin
                if (r.rank < TABLE_DEPTH)
                    o.entry = board[r.rank];
            end
            else
            begin
                // first stored entry that the new one beats; an exact tie goes below
                for (int k = 0; k < TABLE_DEPTH; k++)
                begin
                    if (r.score > board[k].score ||
                        (r.score == board[k].score && r.level > board[k].level))
                    begin
                        for (int m = TABLE_DEPTH - 1; m > k; m--)
                            board[m] = board[m-1];
                        board[k].score   = r.score;
                        board[k].level   = r.level;
                        board[k].episode = r.episode;
                        o.placed         = 1'b1;
                        o.placed_rank    = rank_t'(k);
                        break;
                    end
                end
            end
            expected_outcomes.push_back(o);
        endfunction

        function void check_outcome(outcome_t got);
            outcome_t want;
            if (expected_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("response with no request outstanding: placed=%0d rank=%0d",
                             got.placed, got.placed_rank);
                return;
            end
            want = expected_outcomes.pop_front();
            if (got.placed !== want.placed || got.placed_rank !== want.placed_rank ||
                got.entry !== want.entry)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("mismatch: expected placed=%0d rank=%0d score=%0d level=%0d ep=%0d",
                             want.placed, want.placed_rank, want.entry.score,
                             want.entry.level, want.entry.episode);
                    $display("          got      placed=%0d rank=%0d score=%0d level=%0d ep=%0d",
                             got.placed, got.placed_rank, got.entry.score,
                             got.entry.level, got.entry.episode);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rtki_req_if req_ch ();
    rtki_rsp_if rsp_ch ();

    ranked_top_k_table_insert_core #(
        .NUM_ENTRIES (TABLE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ranked_table_scoreboard sb = new();

    // shared by the sender and the receiver
    bit steady       = 1'b0;  // no idling on either side while set
    bit hold_pending = 1'b0;  // asks the receiver for one long hold-off

    // period 12: high 6, low 6
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int gap_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic request_t insert_req(logic [SCORE_W-1:0] score,
                                            logic [LEVEL_W-1:0] level,
                                            logic [EPISODE_W-1:0] episode);
        request_t r;
        r.cmd     = CMD_INSERT;
        r.score   = score;
        r.level   = level;
        r.episode = episode;
        r.rank    = rank_t'($urandom);
        return r;
    endfunction

    function automatic request_t read_req(rank_t rank);
        request_t r;
        r.cmd     = CMD_READ;
        r.score   = SCORE_W'($urandom);
        r.level   = LEVEL_W'($urandom);
        r.episode = EPISODE_W'($urandom);
        r.rank    = rank;
        return r;
    endfunction

    // random request; scores and levels are often taken from the table itself so
    // that ties, tie breaks and placements at every rank keep happening once the
    // table is full of large scores
    function automatic request_t random_request();
        request_t r;
        entry_t   near;
        int       pick;
        near      = sb.board[$urandom_range(0, TABLE_DEPTH - 1)];
        r.cmd     = ($urandom_range(0, 99) < 35) ? CMD_READ : CMD_INSERT;
        r.rank    = rank_t'($urandom);
        r.episode = EPISODE_W'($urandom);
        pick      = $urandom_range(0, 99);
        if (pick < 30)
        begin
            r.score = SCORE_W'($urandom);
            r.level = LEVEL_W'($urandom);
        end
        else if (pick < 70)
        begin
            // same score as a stored entry, level decides
            r.score = near.score;
            case ($urandom_range(0, 3))
                0:       r.level = near.level;
                1:       r.level = near.level + 1'b1;
                2:       r.level = near.level - 1'b1;
                default: r.level = LEVEL_W'($urandom);
            endcase
        end
        else
        begin
            // just above or just below a stored score
            r.score = ($urandom_range(0, 1) == 1) ? near.score + 1'b1 : near.score - 1'b1;
            r.level = ($urandom_range(0, 1) == 1) ? near.level : LEVEL_W'($urandom);
        end
        return r;
    endfunction

    // offer one request from a falling edge and hold it until accepted
    task automatic send_request(request_t r);
        int gap;
        gap = steady ? 0 : gap_cycles();
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.cmd         = r.cmd;
        req_ch.new_score   = r.score;
        req_ch.new_level   = r.level;
        req_ch.new_episode = r.episode;
        req_ch.read_rank   = r.rank;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // receiver: random stalls, one long hold-off on demand, counted here in cycles
    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                stall_left   = steady ? 0 : gap_cycles();
            end
        end
    end

    // both channels sampled at the rising edge; the response check goes first
    always @(posedge clk)
    begin
        outcome_t got;
        request_t seen;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.placed        = rsp_ch.placed;
                got.placed_rank   = rsp_ch.placed_rank;
                got.entry.score   = rsp_ch.entry_score;
                got.entry.level   = rsp_ch.entry_level;
                got.entry.episode = rsp_ch.entry_episode;
                sb.check_outcome(got);
            end
            if (req_ch.valid && req_ch.ready)
            begin
                seen.cmd     = req_ch.cmd;
                seen.score   = req_ch.new_score;
                seen.level   = req_ch.new_level;
                seen.episode = req_ch.new_episode;
                seen.rank    = req_ch.read_rank;
                sb.note_request(seen);
            end
        end
    end

    // watchdog
    int unsigned cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_INSERT;
        req_ch.new_score   = '0;
        req_ch.new_level   = '0;
        req_ch.new_episode = '0;
        req_ch.read_rank   = '0;
        rst_n              = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table reads back zeros
        send_request(read_req(3'd0));
        send_request(read_req(3'd7));
        // all-zero entry beats nothing in a cleared table
        send_request(insert_req('0, '0, '0));
        // largest score and level straight to the top
        send_request(insert_req('1, '1, 3'd7));
        // exact tie lands below the stored one
        send_request(insert_req('1, '1, 3'd0));
        // same score, lower level: goes after both
        send_request(insert_req('1, '0, 3'd7));
        // zero score wins on level alone
        send_request(insert_req('0, 16'd1, 3'd5));
        send_request(insert_req('0, 16'd1, 3'd2));
        send_request(insert_req(31'd1, '0, 3'd1));
        // alternating bit patterns, the table fills and the tail drops out
        send_request(insert_req(31'h5555_5555, 16'hAAAA, 3'd4));
        send_request(insert_req(31'h2AAA_AAAA, 16'h5555, 3'd3));
        send_request(insert_req(31'd1000, 16'd7, 3'd6));
        // placement at the last rank
        send_request(insert_req('0, '1, 3'd1));
        // full table of better entries: not placed; then a top score placed on level
        send_request(insert_req('0, '0, '0));
        send_request(insert_req('1, 16'd1, 3'd2));
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_request(read_req(rank_t'(k)));

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // receiver holds off for a long stretch while requests keep coming
            if (n == 300)
            begin
                hold_pending = 1'b1;
                steady       = 1'b1;
            end
            if (n == 340)
                steady = 1'b0;
            // sender waits until every response is back, then resumes
            if (n == 900)
            begin
                req_ch.valid = 1'b0;
                while (sb.pending() != 0)
                    @(negedge clk);
            end
            // a stretch with no idling at all
            if (n == 1200)
                steady = 1'b1;
            if (n == 1450)
                steady = 1'b0;
            send_request(random_request());
        end
        req_ch.valid = 1'b0;

        // drain, then keep watching to catch anything extra
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
